// ===== hw/rtl/pwm_duty_fader_top_macros.svh =====
// Assertion macros shared by the duty fader RTL files.
`ifndef PWM_DUTY_FADER_TOP_MACROS_SVH
`define PWM_DUTY_FADER_TOP_MACROS_SVH

// Same-cycle implication, sampled on i_clk, off while i_rst_n is low.
`define PF_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, sampled on i_clk, off while i_rst_n is low.
`define PF_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

// ===== hw/rtl/pwmfade_pkg.sv =====
// Shared types, constants and codes for the PWM duty fader.
`timescale 1ns / 1ps

package pwmfade_pkg;

    // Field widths
    localparam int OPCODE_W   = 2;
    localparam int VALUE_W    = 9;
    localparam int DUTY_W     = 9;
    localparam int PERCENT_W  = 7;
    localparam int STEP_W     = 8;
    localparam int STEPS_W    = 7;
    localparam int INTERVAL_W = 16;

    // Value limits
    localparam logic [DUTY_W-1:0]    DUTY_MAX = 9'd256;
    localparam logic [PERCENT_W-1:0] PCT_MAX  = 7'd100;

    // Default number of increments in one fade
    localparam int FADE_STEPS_DEF = 16;

    // Reciprocal of 100 for the percent-to-raw conversion, exact for 0..25600
    localparam int               PCT_RECIP_SH = 22;
    localparam logic [15:0]      PCT_RECIP    = 16'((2**PCT_RECIP_SH + 99) / 100);

    // Item opcodes
    localparam logic [OPCODE_W-1:0] OP_TICK    = 2'd0;
    localparam logic [OPCODE_W-1:0] OP_SET_RAW = 2'd1;
    localparam logic [OPCODE_W-1:0] OP_SET_PCT = 2'd2;

    // Configuration register indexes
    localparam logic REG_FADE_INTERVAL = 1'b0;

    // APB port widths
    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;

    // One input item
    typedef struct packed {
        logic [OPCODE_W-1:0] opcode;
        logic [VALUE_W-1:0]  value;
    } t_item;

    // One result item
    typedef struct packed {
        logic [DUTY_W-1:0]    duty;
        logic [PERCENT_W-1:0] duty_percent;
        logic                 duty_written;
    } t_result;

endpackage

// ===== hw/rtl/pwm_duty_fader_top.sv =====
// pwm_duty_fader_top: ramps a PWM duty toward a target over FADE_STEPS increments.
// Each input item is a millisecond tick or a new target (raw 0..256 or percent),
// and every item yields exactly one result: the duty, its percent and a flag
// that says whether the duty was rewritten. An item is held in the input
// register, where the fade state is updated, and from there lands in the result register,
// and a new item is taken every cycle as long as the result side keeps up; a
// stalled result holds the result register and keeps the next item waiting in the
// input register, and the input stalls once that is full.
// fade_interval_ms lives at APB byte address 0 and may be written while idle.
`timescale 1ns / 1ps
`include "pwm_duty_fader_top_macros.svh"

module pwm_duty_fader_top
    import pwmfade_pkg::*;
#(
    parameter int FADE_STEPS = FADE_STEPS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  logic [OPCODE_W-1:0]   i_opcode,
    input  logic [VALUE_W-1:0]    i_value,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output logic [DUTY_W-1:0]     o_duty,
    output logic [PERCENT_W-1:0]  o_duty_percent,
    output logic                  o_duty_written,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready
);

    logic                  r_in_valid;
    t_item                 r_item;
    logic                  r_out_valid;
    t_result               r_result;
    t_result               w_result;
    logic                  w_adv;
    logic                  w_in_take;
    logic [INTERVAL_W-1:0] w_fade_interval;

    pwmfade_cfg u_cfg (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready),
        .o_fade_interval (w_fade_interval)
    );

    pwmfade_core #(
        .FADE_STEPS (FADE_STEPS)
    ) u_core (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_adv           (w_adv),
        .i_item          (r_item),
        .i_fade_interval (w_fade_interval),
        .o_result        (w_result)
    );

    // Advance the held item whenever the result register is free or draining
    assign w_adv      = r_in_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall = r_in_valid && !w_adv;
    assign w_in_take  = i_in_valid && !o_in_stall;

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (w_in_take) begin
            r_in_valid <= 1'b1;
        end else if (w_adv) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_take) begin
            r_item.opcode <= i_opcode;
            r_item.value  <= i_value;
        end
    end

    // Result register: load on advance, drop once taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_adv) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_result <= w_result;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_duty         = r_result.duty;
    assign o_duty_percent = r_result.duty_percent;
    assign o_duty_written = r_result.duty_written;

    `PF_ASSERT_NEXT(a_adv_fills_out, w_adv, r_out_valid, "advanced item missing at output")
    `PF_ASSERT_NEXT(a_stalled_out_kept, r_out_valid && i_out_stall && !w_adv,
        r_out_valid, "stalled result dropped")
    `PF_ASSERT_NOW(a_take_needs_room, w_in_take && r_in_valid, w_adv,
        "input item overwrote a held item")

endmodule

// ===== hw/rtl/pwmfade_cfg.sv =====
// APB register file holding the fade interval.
`timescale 1ns / 1ps

module pwmfade_cfg
    import pwmfade_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready,
    output logic [INTERVAL_W-1:0] o_fade_interval
);

    logic [INTERVAL_W-1:0] r_fade_interval;
    logic                  w_wr;
    logic                  w_index;

    assign pready  = 1'b1;
    assign w_index = paddr[APB_ADDR_W-1];
    assign w_wr    = psel && penable && pwrite;

    // Write the interval register on the access phase
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fade_interval <= '0;
        end else if (w_wr && (w_index == REG_FADE_INTERVAL)) begin
            r_fade_interval <= pwdata[INTERVAL_W-1:0];
        end
    end

    // Decode reads
    always_comb begin
        unique case (w_index)
            REG_FADE_INTERVAL: prdata = APB_DATA_W'(r_fade_interval);
            default:           prdata = '0;
        endcase
    end

    assign o_fade_interval = r_fade_interval;

endmodule

// ===== hw/rtl/pwmfade_core.sv =====
// Fade state registers and the single-pass update for one item.
`timescale 1ns / 1ps
`include "pwm_duty_fader_top_macros.svh"

module pwmfade_core
    import pwmfade_pkg::*;
#(
    parameter int FADE_STEPS = FADE_STEPS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_adv,
    input  t_item                 i_item,
    input  logic [INTERVAL_W-1:0] i_fade_interval,
    output t_result               o_result
);

    // Reciprocal of FADE_STEPS, exact for magnitudes up to 256
    localparam int              STEP_RECIP_SH = 16;
    localparam logic [16:0]     STEP_RECIP    =
        17'((2**STEP_RECIP_SH + FADE_STEPS - 1) / FADE_STEPS);
    localparam logic [STEPS_W-1:0] STEPS_LAST = STEPS_W'(FADE_STEPS);

    logic [DUTY_W-1:0]     r_cur, n_cur;
    logic [DUTY_W-1:0]     r_target, n_target;
    logic [STEP_W-1:0]     r_step, n_step;
    logic [STEPS_W-1:0]    r_steps, n_steps;
    logic [INTERVAL_W-1:0] r_elapsed, n_elapsed;
    logic                  w_written;

    logic [PERCENT_W-1:0]  w_pct_in;
    logic [30:0]           w_pct_prod;
    logic [DUTY_W-1:0]     w_set_target;
    logic signed [9:0]     w_diff;
    logic [DUTY_W-1:0]     w_mag;
    logic [25:0]           w_step_prod;
    logic [STEP_W-1:0]     w_quot;
    logic [STEP_W-1:0]     w_new_step;
    logic [INTERVAL_W-1:0] w_elapsed_inc;
    logic signed [10:0]    w_sum;
    logic [DUTY_W-1:0]     w_stepped;
    logic [15:0]           w_out_prod;

    // Resolve the target of a set item, raw or percent, saturated
    always_comb begin
        w_pct_in   = (i_item.value > VALUE_W'(PCT_MAX)) ? PCT_MAX
                                                         : i_item.value[PERCENT_W-1:0];
        w_pct_prod = 31'({w_pct_in, 8'd0}) * 31'(PCT_RECIP);
        if (i_item.opcode == OP_SET_PCT) begin
            w_set_target = w_pct_prod[30:PCT_RECIP_SH];
        end else begin
            w_set_target = (i_item.value > DUTY_MAX) ? DUTY_MAX : i_item.value;
        end
    end

    // Step size: difference over FADE_STEPS, truncated, at least one for a nonzero difference
    always_comb begin
        w_diff      = signed'({1'b0, w_set_target}) - signed'({1'b0, r_cur});
        w_mag       = w_diff[9] ? DUTY_W'(-w_diff) : DUTY_W'(w_diff);
        w_step_prod = 26'(w_mag) * 26'(STEP_RECIP);
        w_quot      = STEP_W'(w_step_prod[25:STEP_RECIP_SH]);
        if ((w_quot == '0) && (w_mag != '0)) begin
            w_quot = STEP_W'(1);
        end
        w_new_step  = w_diff[9] ? STEP_W'(-w_quot) : w_quot;
    end

    // One increment applied to the duty, clamped to 0..256
    always_comb begin
        w_sum = signed'({2'b00, r_cur}) + signed'({{3{r_step[STEP_W-1]}}, r_step});
        if (w_sum[10]) begin
            w_stepped = '0;
        end else if (w_sum > signed'(11'(DUTY_MAX))) begin
            w_stepped = DUTY_MAX;
        end else begin
            w_stepped = w_sum[DUTY_W-1:0];
        end
    end

    assign w_elapsed_inc = (&r_elapsed) ? r_elapsed : r_elapsed + 1'b1;

    // Next state for the item in hand
    always_comb begin
        n_cur     = r_cur;
        n_target  = r_target;
        n_step    = r_step;
        n_steps   = r_steps;
        n_elapsed = r_elapsed;
        w_written = 1'b0;
        case (i_item.opcode) inside
            OP_TICK: begin
                n_elapsed = w_elapsed_inc;
                if (r_target == r_cur) begin
                    n_steps = '0;
                end else if (i_fade_interval == '0) begin
                    n_cur     = r_target;
                    w_written = 1'b1;
                end else if (w_elapsed_inc >= i_fade_interval) begin
                    if (r_steps == STEPS_LAST) begin
                        n_cur   = r_target;
                        n_steps = '0;
                    end else begin
                        n_cur   = w_stepped;
                        n_steps = r_steps + 1'b1;
                    end
                    n_elapsed = '0;
                    w_written = 1'b1;
                end
            end
            OP_SET_RAW, OP_SET_PCT: begin
                n_target  = w_set_target;
                n_step    = w_new_step;
                n_elapsed = '0;
            end
            default: begin
            end
        endcase
    end

    // Hold state, advance on each item
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cur     <= '0;
            r_target  <= '0;
            r_step    <= '0;
            r_steps   <= '0;
            r_elapsed <= '0;
        end else if (i_adv) begin
            r_cur     <= n_cur;
            r_target  <= n_target;
            r_step    <= n_step;
            r_steps   <= n_steps;
            r_elapsed <= n_elapsed;
        end
    end

    // Result from the updated duty
    assign w_out_prod            = 16'(n_cur) * 16'(PCT_MAX);
    assign o_result.duty         = n_cur;
    assign o_result.duty_percent = w_out_prod[14:8];
    assign o_result.duty_written = w_written;

    `PF_ASSERT_NOW(a_duty_range, 1'b1, r_cur <= DUTY_MAX, "duty above range")
    `PF_ASSERT_NOW(a_steps_range, 1'b1, r_steps <= STEPS_LAST, "step count past fade length")
    `PF_ASSERT_NOW(a_write_on_tick, w_written, i_item.opcode == OP_TICK,
        "duty written by a non-tick item")
    `PF_ASSERT_NEXT(a_set_clears, i_adv && (i_item.opcode == OP_SET_RAW ||
        i_item.opcode == OP_SET_PCT), r_elapsed == '0, "set item left tick count")

endmodule
